[sv/pmr_pkg.sv]
// ----------------------------------------------------------------------------
// pmr_pkg
// Shared types and constants of the packet min/max/parity reducer.
// ----------------------------------------------------------------------------
package pmr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 7;
  localparam int unsigned WordW  = 9;
  localparam int unsigned NWords = 4;

  // Where the stream parser stands.
  typedef enum logic [1:0] {
    PH_OPCODE = 2'd0,
    PH_COUNT  = 2'd1,
    PH_DATA   = 2'd2
  } phase_e;

  // Opcodes.
  localparam logic [ByteW-1:0] OP_MIN     = 8'd0;
  localparam logic [ByteW-1:0] OP_MAX     = 8'd1;
  localparam logic [ByteW-1:0] OP_ODD     = 8'd2;
  localparam logic [ByteW-1:0] OP_EVEN    = 8'd3;
  localparam logic [ByteW-1:0] OP_MINMAX  = 8'd4;
  localparam logic [ByteW-1:0] OP_ODDEVEN = 8'd5;
  localparam logic [ByteW-1:0] OP_EOS     = 8'hFF;

  // One finished packet: the words to send and the index of the last one.
  typedef struct packed {
    logic [NWords-1:0][WordW-1:0] words;
    logic [1:0]                   last_idx;
  } rec_t;

endpackage

[sv/pmr_in_if.sv]
// ----------------------------------------------------------------------------
// pmr_in_if
// Input byte channel: valid/ready handshake with one stream byte.
// ----------------------------------------------------------------------------
interface pmr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

[sv/pmr_out_if.sv]
// ----------------------------------------------------------------------------
// pmr_out_if
// Result channel: valid/ready handshake with one result word and its end flag.
// ----------------------------------------------------------------------------
interface pmr_out_if;
  logic              valid;
  logic              ready;
  logic signed [8:0] out_word;
  logic              is_last;

  modport source (output valid, output out_word, output is_last, input ready);
  modport sink (input valid, input out_word, input is_last, output ready);
endinterface

[sv/pmr_reduce.sv]
// ----------------------------------------------------------------------------
// pmr_reduce
// Stream parser and running reduction; builds the result words of a packet.
// ----------------------------------------------------------------------------
module pmr_reduce (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       take_i,
  input  logic [pmr_pkg::ByteW-1:0]  byte_i,
  output logic                       fin_o,
  output pmr_pkg::rec_t              rec_o
);

  pmr_pkg::phase_e phase_q, phase_d;
  logic [pmr_pkg::ByteW-1:0]  op_q, op_d;
  logic [pmr_pkg::CountW-1:0] left_q, left_d;
  logic signed [pmr_pkg::ByteW-1:0] min_q, min_d, max_q, max_d;
  logic [pmr_pkg::CountW-1:0] odd_q, odd_d, even_q, even_d;

  logic signed [pmr_pkg::ByteW-1:0] val;
  logic                             first;
  logic                             empty_cnt;
  logic [pmr_pkg::CountW-1:0]       left_dec;
  logic                             fin;
  logic signed [pmr_pkg::ByteW-1:0] r_min, r_max;
  logic [pmr_pkg::CountW-1:0]       r_odd, r_even;

  assign val       = $signed(byte_i);
  assign first     = ({1'b0, odd_q} + {1'b0, even_q}) == '0;
  assign empty_cnt = (byte_i == '0) || byte_i[pmr_pkg::ByteW-1];
  assign left_dec  = left_q - 1'b1;

  // Next state of the parser.
  always_comb begin
    phase_d = phase_q;
    fin     = 1'b0;
    if (take_i) begin
      unique case (phase_q)
        pmr_pkg::PH_COUNT: begin
          if (empty_cnt) begin
            phase_d = pmr_pkg::PH_OPCODE;
            fin     = 1'b1;
          end else begin
            phase_d = pmr_pkg::PH_DATA;
          end
        end
        pmr_pkg::PH_DATA: begin
          if (left_dec == '0) begin
            phase_d = pmr_pkg::PH_OPCODE;
            fin     = 1'b1;
          end
        end
        default: begin
          // An end-of-stream marker leaves the parser waiting for an opcode.
          if (byte_i != pmr_pkg::OP_EOS) begin
            phase_d = pmr_pkg::PH_COUNT;
          end
        end
      endcase
    end
  end

  // Running reduction.
  always_comb begin
    op_d   = op_q;
    left_d = left_q;
    r_min  = min_q;
    r_max  = max_q;
    r_odd  = odd_q;
    r_even = even_q;
    if (take_i) begin
      unique case (phase_q)
        pmr_pkg::PH_COUNT: begin
          r_min  = '0;
          r_max  = '0;
          r_odd  = '0;
          r_even = '0;
          left_d = empty_cnt ? '0 : byte_i[pmr_pkg::CountW-1:0];
        end
        pmr_pkg::PH_DATA: begin
          if (first) begin
            r_min = val;
            r_max = val;
          end else begin
            if (val < min_q) r_min = val;
            if (val > max_q) r_max = val;
          end
          if (byte_i[0]) begin
            r_odd = odd_q + 1'b1;
          end else begin
            r_even = even_q + 1'b1;
          end
          left_d = left_dec;
        end
        default: begin
          if (byte_i != pmr_pkg::OP_EOS) begin
            op_d = byte_i;
          end
        end
      endcase
    end
    // A finished packet starts the next one from a clean slate.
    if (fin) begin
      min_d  = '0;
      max_d  = '0;
      odd_d  = '0;
      even_d = '0;
      left_d = '0;
    end else begin
      min_d  = r_min;
      max_d  = r_max;
      odd_d  = r_odd;
      even_d = r_even;
    end
  end

  // Result words of the packet that ends in this transfer.
  always_comb begin
    logic [pmr_pkg::WordW-1:0] w_min, w_max, w_odd, w_even;
    w_min  = {r_min[pmr_pkg::ByteW-1], r_min};
    w_max  = {r_max[pmr_pkg::ByteW-1], r_max};
    w_odd  = {2'b00, r_odd};
    w_even = {2'b00, r_even};
    rec_o.words[0] = {1'b0, op_q};
    rec_o.words[1] = '0;
    rec_o.words[2] = '0;
    rec_o.words[3] = '0;
    rec_o.last_idx = 2'd2;
    unique case (op_q)
      pmr_pkg::OP_MIN: begin
        rec_o.words[1] = pmr_pkg::WordW'(1);
        rec_o.words[2] = w_min;
      end
      pmr_pkg::OP_MAX: begin
        rec_o.words[1] = pmr_pkg::WordW'(1);
        rec_o.words[2] = w_max;
      end
      pmr_pkg::OP_ODD: begin
        rec_o.words[1] = pmr_pkg::WordW'(1);
        rec_o.words[2] = w_odd;
      end
      pmr_pkg::OP_EVEN: begin
        rec_o.words[1] = pmr_pkg::WordW'(1);
        rec_o.words[2] = w_even;
      end
      pmr_pkg::OP_MINMAX: begin
        rec_o.words[1] = pmr_pkg::WordW'(2);
        rec_o.words[2] = w_min;
        rec_o.words[3] = w_max;
        rec_o.last_idx = 2'd3;
      end
      pmr_pkg::OP_ODDEVEN: begin
        rec_o.words[1] = pmr_pkg::WordW'(2);
        rec_o.words[2] = w_odd;
        rec_o.words[3] = w_even;
        rec_o.last_idx = 2'd3;
      end
      default: begin
        // Unknown opcode: echo it and report no results.
        rec_o.last_idx = 2'd1;
      end
    endcase
  end

  assign fin_o = fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pmr_pkg::PH_OPCODE;
      op_q    <= '0;
      left_q  <= '0;
      min_q   <= '0;
      max_q   <= '0;
      odd_q   <= '0;
      even_q  <= '0;
    end else begin
      phase_q <= phase_d;
      op_q    <= op_d;
      left_q  <= left_d;
      min_q   <= min_d;
      max_q   <= max_d;
      odd_q   <= odd_d;
      even_q  <= even_d;
    end
  end

endmodule

[sv/pmr_emit.sv]
// ----------------------------------------------------------------------------
// pmr_emit
// Holds finished packets and sends their words one transfer at a time.
// ----------------------------------------------------------------------------
module pmr_emit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fin_i,
  input  pmr_pkg::rec_t              rec_i,
  output logic                       full_o,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [pmr_pkg::WordW-1:0]  word_o,
  output logic                       last_o
);

  pmr_pkg::rec_t pend_q, cur_q;
  logic          pend_vld_q, pend_vld_d;
  logic          cur_vld_q, cur_vld_d;
  logic [1:0]    idx_q, idx_d;
  logic          cur_done;
  logic          load;

  assign valid_o  = cur_vld_q;
  assign word_o   = cur_q.words[idx_q];
  assign last_o   = (idx_q == cur_q.last_idx);
  assign cur_done = cur_vld_q && ready_i && last_o;
  assign load     = pend_vld_q && (!cur_vld_q || cur_done);
  // With the send register empty the held packet moves on at this edge, so the
  // holding register can take a new packet at the same time.
  assign full_o   = pend_vld_q && cur_vld_q;

  always_comb begin
    pend_vld_d = pend_vld_q;
    cur_vld_d  = cur_vld_q;
    idx_d      = idx_q;
    if (fin_i) begin
      pend_vld_d = 1'b1;
    end else if (load) begin
      pend_vld_d = 1'b0;
    end
    if (load) begin
      cur_vld_d = 1'b1;
      idx_d     = '0;
    end else if (cur_done) begin
      cur_vld_d = 1'b0;
      idx_d     = '0;
    end else if (cur_vld_q && ready_i) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      cur_vld_q  <= 1'b0;
      idx_q      <= '0;
    end else begin
      pend_vld_q <= pend_vld_d;
      cur_vld_q  <= cur_vld_d;
      idx_q      <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_i) pend_q <= rec_i;
    if (load) cur_q <= pend_q;
  end

endmodule

[sv/packet_min_max_parity_reducer.sv]
// ----------------------------------------------------------------------------
// packet_min_max_parity_reducer
// Parses opcode/count/data packets and reports min, max and parity counts.
//
// Channel   Dir  Payload               Transfer
// in_if     in   in_byte[7:0]          valid && ready
// out_if    out  out_word[8:0] signed, valid && ready
//                is_last
//
// One input byte per cycle is taken while the result slot is free; each byte
// updates the running state in the same cycle. A finished packet lands in a
// one-entry holding register, moves to the send register, and goes out as two
// to four words, one per cycle while out_if.ready is high. Input stalls only
// while both the holding and the send register are occupied.
// Reset clears all parser state and drops any pending words.
// ----------------------------------------------------------------------------
module packet_min_max_parity_reducer (
  input  logic       clk_i,
  input  logic       rst_ni,
  pmr_in_if.sink     in_if,
  pmr_out_if.source  out_if
);

  logic                          take;
  logic                          fin;
  pmr_pkg::rec_t                 rec;
  logic                          full;
  logic [pmr_pkg::WordW-1:0]     word;

  assign in_if.ready = !full;
  assign take        = in_if.valid && !full;

  pmr_reduce u_reduce (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .byte_i (in_if.in_byte),
    .fin_o  (fin),
    .rec_o  (rec)
  );

  pmr_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fin_i   (fin),
    .rec_i   (rec),
    .full_o  (full),
    .valid_o (out_if.valid),
    .ready_i (out_if.ready),
    .word_o  (word),
    .last_o  (out_if.is_last)
  );

  assign out_if.out_word = $signed(word);

endmodule

[dv/tb_packet_min_max_parity_reducer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_packet_min_max_parity_reducer
// Drives opcode/count/data packets into the reducer with random gaps on the
// input and random stalls on the output. A predictor tracks the parser state
// per accepted byte and queues the words each finished packet should produce.
// Every word taken from the result channel is checked field by field.
// ----------------------------------------------------------------------------
module tb_packet_min_max_parity_reducer;

  localparam int unsigned NumItems    = 370;
  localparam int unsigned TailItems   = 50;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 20;

  // One stream byte; hold makes the sender wait until no word is owed.
  typedef struct packed {
    logic [pmr_pkg::ByteW-1:0] data;
    logic                      hold;
  } stim_t;

  typedef struct packed {
    logic [pmr_pkg::WordW-1:0] word;
    logic                      last;
  } word_t;

  logic                      clk_i     = 1'b0;
  logic                      rst_ni    = 1'b0;
  logic                      drv_valid = 1'b0;
  logic [pmr_pkg::ByteW-1:0] drv_byte  = '0;
  logic                      drv_ready = 1'b0;
  logic                      in_taken  = 1'b0;

  pmr_in_if  in_if ();
  pmr_out_if out_if ();

  assign in_if.valid   = drv_valid;
  assign in_if.in_byte = drv_byte;
  assign out_if.ready  = drv_ready;

  packet_min_max_parity_reducer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if)
  );

  stim_t       stream_q[$];
  word_t       expected_words[$];
  int unsigned n_items     = 0;
  int unsigned err_cnt     = 0;
  int unsigned idle_cycles = 0;
  int unsigned in_gap      = 0;
  int unsigned out_gap     = 0;

  // Predictor state.
  pmr_pkg::phase_e            ph      = pmr_pkg::PH_OPCODE;
  logic [pmr_pkg::ByteW-1:0]  held_op = '0;
  logic [pmr_pkg::CountW-1:0] left    = '0;
  logic [pmr_pkg::CountW-1:0] odd_n   = '0;
  logic [pmr_pkg::CountW-1:0] even_n  = '0;
  logic signed [7:0]          lo      = '0;
  logic signed [7:0]          hi      = '0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report(input string msg);
    $display("%0t ERROR %s", $time, msg);
    err_cnt++;
  endtask

  task automatic push_word(input logic [pmr_pkg::WordW-1:0] w, input logic last);
    expected_words.push_back('{word: w, last: last});
  endtask

  task automatic clear_run();
    left   = '0;
    lo     = '0;
    hi     = '0;
    odd_n  = '0;
    even_n = '0;
  endtask

  task automatic emit_packet();
    push_word({1'b0, held_op}, 1'b0);
    case (held_op)
      pmr_pkg::OP_MIN: begin
        push_word(9'd1, 1'b0);
        push_word({lo[7], lo}, 1'b1);
      end
      pmr_pkg::OP_MAX: begin
        push_word(9'd1, 1'b0);
        push_word({hi[7], hi}, 1'b1);
      end
      pmr_pkg::OP_ODD: begin
        push_word(9'd1, 1'b0);
        push_word({2'b00, odd_n}, 1'b1);
      end
      pmr_pkg::OP_EVEN: begin
        push_word(9'd1, 1'b0);
        push_word({2'b00, even_n}, 1'b1);
      end
      pmr_pkg::OP_MINMAX: begin
        push_word(9'd2, 1'b0);
        push_word({lo[7], lo}, 1'b0);
        push_word({hi[7], hi}, 1'b1);
      end
      pmr_pkg::OP_ODDEVEN: begin
        push_word(9'd2, 1'b0);
        push_word({2'b00, odd_n}, 1'b0);
        push_word({2'b00, even_n}, 1'b1);
      end
      default: begin
        push_word(9'd0, 1'b1);
      end
    endcase
    ph = pmr_pkg::PH_OPCODE;
    clear_run();
  endtask

  task automatic reduce_byte(input logic [pmr_pkg::ByteW-1:0] b);
    logic signed [7:0] v;
    v = $signed(b);
    case (ph)
      pmr_pkg::PH_COUNT: begin
        clear_run();
        // A count with the sign bit set behaves like an empty packet.
        if (b == '0 || b[7]) begin
          emit_packet();
        end else begin
          left = b[pmr_pkg::CountW-1:0];
          ph   = pmr_pkg::PH_DATA;
        end
      end
      pmr_pkg::PH_DATA: begin
        // No value counted yet means this one seeds both extremes.
        if (odd_n == '0 && even_n == '0) begin
          lo = v;
          hi = v;
        end else begin
          if (v < lo) lo = v;
          if (v > hi) hi = v;
        end
        if (b[0]) odd_n++;
        else even_n++;
        left--;
        if (left == '0) emit_packet();
      end
      default: begin
        if (b != pmr_pkg::OP_EOS) begin
          held_op = b;
          ph      = pmr_pkg::PH_COUNT;
        end
      end
    endcase
  endtask

  task automatic put_byte(input logic [pmr_pkg::ByteW-1:0] b, input logic hold = 1'b0);
    stream_q.push_back('{data: b, hold: hold});
    n_items++;
  endtask

  function automatic logic [pmr_pkg::ByteW-1:0] rand_data();
    case ($urandom_range(0, 9))
      0: return 8'h80;
      1: return 8'h7F;
      2: return 8'h00;
      3: return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  task automatic send_packet(input logic [pmr_pkg::ByteW-1:0] op,
                             input logic [pmr_pkg::ByteW-1:0] cnt,
                             input logic hold);
    put_byte(op, hold);
    put_byte(cnt);
    if (!cnt[7]) begin
      for (int i = 0; i < int'(cnt); i++) put_byte(rand_data());
    end
  endtask

  // Input driver: presents the next byte at the falling edge once the
  // previous one has been transferred.
  always @(negedge clk_i) begin
    logic                      v;
    logic [pmr_pkg::ByteW-1:0] d;
    stim_t                     nxt;
    v = drv_valid;
    d = drv_byte;
    if (rst_ni && !(drv_valid && !in_taken)) begin
      v = 1'b0;
      if (in_gap != 0) begin
        in_gap--;
      end else if (stream_q.size() != 0 &&
                   !(stream_q[0].hold && expected_words.size() != 0)) begin
        if (stream_q.size() > TailItems && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(0, 7);
        end else begin
          nxt = stream_q.pop_front();
          v   = 1'b1;
          d   = nxt.data;
        end
      end
    end
    drv_valid <= v;
    drv_byte  <= d;
  end

  // Result sink: ready drops in bursts until the tail of the stream.
  always @(negedge clk_i) begin
    logic r;
    r = 1'b0;
    if (rst_ni) begin
      if (out_gap != 0) begin
        out_gap--;
      end else if (stream_q.size() > TailItems && $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(0, 7);
      end else begin
        r = 1'b1;
      end
    end
    drv_ready <= r;
  end

  // Monitor and watchdog.
  always @(posedge clk_i) begin
    word_t want;
    logic  out_taken;
    if (rst_ni) begin
      in_taken  = in_if.valid && in_if.ready;
      out_taken = out_if.valid && out_if.ready;
      if (in_taken) reduce_byte(in_if.in_byte);
      if (out_taken) begin
        if (expected_words.size() == 0) begin
          report($sformatf("unexpected word %0d is_last %0b",
                           $signed(out_if.out_word), out_if.is_last));
        end else begin
          want = expected_words.pop_front();
          if (out_if.out_word !== want.word) begin
            report($sformatf("out_word %0d, expected %0d",
                             $signed(out_if.out_word), $signed(want.word)));
          end
          if (out_if.is_last !== want.last) begin
            report($sformatf("is_last %0b, expected %0b", out_if.is_last, want.last));
          end
        end
      end
      if (in_taken || out_taken) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("tb_packet_min_max_parity_reducer: errors");
        $finish;
      end
    end
  end

  initial begin
    logic [pmr_pkg::ByteW-1:0] op;
    logic [pmr_pkg::ByteW-1:0] cnt;

    // An end-of-stream byte in opcode position is dropped.
    stream_q.push_back('{data: pmr_pkg::OP_EOS, hold: 1'b0});
    put_byte(pmr_pkg::OP_MIN);
    put_byte(8'd3);
    put_byte(8'h80);
    put_byte(8'h7F);
    put_byte(8'h01);
    put_byte(pmr_pkg::OP_MAX);
    put_byte(8'd1);
    put_byte(8'h80);
    // Empty packet, then the two ends of the negative count range.
    put_byte(pmr_pkg::OP_ODD);
    put_byte(8'd0);
    put_byte(pmr_pkg::OP_EVEN);
    put_byte(8'h80);
    put_byte(pmr_pkg::OP_MINMAX);
    put_byte(8'hFF);
    put_byte(pmr_pkg::OP_ODDEVEN);
    put_byte(8'd2);
    put_byte(8'h00);
    put_byte(8'hFF);
    // Unknown opcodes still consume their data bytes.
    put_byte(pmr_pkg::OP_ODDEVEN + 8'd1);
    put_byte(8'd2);
    put_byte(8'h55);
    put_byte(8'hAA);
    put_byte(pmr_pkg::OP_EOS - 8'd1);
    put_byte(8'd1);
    put_byte(8'h7F);

    // Longest packet, sent only after every earlier word is out.
    send_packet(pmr_pkg::OP_ODDEVEN, 8'd127, 1'b1);

    while (n_items < NumItems) begin
      case ($urandom_range(0, 19))
        0: stream_q.push_back('{data: pmr_pkg::OP_EOS, hold: 1'b0});
        1: repeat ($urandom_range(1, 3)) put_byte(8'($urandom()));
        default: begin
          if ($urandom_range(0, 7) < 6) begin
            op = 8'($urandom_range(pmr_pkg::OP_MIN, pmr_pkg::OP_ODDEVEN));
          end else begin
            op = 8'($urandom_range(pmr_pkg::OP_ODDEVEN + 1, pmr_pkg::OP_EOS - 1));
          end
          case ($urandom_range(0, 19))
            0: cnt = '0;
            1: cnt = 8'($urandom_range(128, 255));
            2: cnt = 8'($urandom_range(8, 40));
            default: cnt = 8'($urandom_range(1, 6));
          endcase
          send_packet(op, cnt, $urandom_range(0, 24) == 0);
        end
      endcase
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (stream_q.size() != 0 || drv_valid) @(negedge clk_i);
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (err_cnt == 0) begin
      $display("tb_packet_min_max_parity_reducer: clean");
    end else begin
      $display("tb_packet_min_max_parity_reducer: errors");
    end
    $finish;
  end

endmodule
